@@ rtl/core/qmvn_pkg.sv @@
package qmvn_pkg;

  localparam int CoordBits = 16;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int CrossBits = 2 * EdgeBits + 1;
  localparam int SumBits   = CrossBits + 1;
  localparam int MagBits   = 16;
  localparam int SqBits    = 2 * MagBits + 2;
  localparam int DotBits   = SumBits + CoordBits + 2;
  localparam int QBits     = 15;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [SumBits-1:0]   nsum_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X1,
    ST_X2,
    ST_X3,
    ST_X4,
    ST_X5,
    ST_X6,
    ST_NSET,
    ST_NORM,
    ST_SQ,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

@@ rtl/core/quad_mesh_vertex_normals.sv @@
// quad mesh vertex normals, area weighted
// input channel: one vertex per beat (in_vertex_x/y/z, signed q4.12)
// every four vertices form a quad split into triangles (0,1,2) and (0,2,3)
// output channel: after the fourth vertex, four beats of q1.14 normals in
// corner order, out_last_of_quad marks the fourth one
// the first three vertices of a quad are only stored; in_ready stays high
// the fourth vertex starts a sequencer that reuses one multiplier: cross
// products first (six terms, two products each), then per corner a sum
// load, a scale step with the orientation dot, three squares and three
// bit-serial ratio searches; a zero sum skips the searches
// in_ready is low while the sequencer runs
// out_valid holds with its payload until out_ready; the sequencer waits there
// a degenerate corner gives a zero normal and out_degenerate
// reset (synchronous, rst_n low) clears the corner count and sequencer
module quad_mesh_vertex_normals (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_vertex_x,
  input  logic signed [15:0]               in_vertex_y,
  input  logic signed [15:0]               in_vertex_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               out_normal_x,
  output logic signed [15:0]               out_normal_y,
  output logic signed [15:0]               out_normal_z,
  output logic [1:0]                       out_corner,
  output logic                             out_degenerate,
  output logic                             out_last_of_quad
);
  import qmvn_pkg::*;

  state_t st_r, st_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  coord_t vb_r [4][3];
  logic signed [CrossBits-1:0] na_r [3];
  logic signed [CrossBits-1:0] nb_r [3];
  nsum_t n_r [3];
  logic [1:0] k_r, k_nxt;
  logic [1:0] c_r, c_nxt;
  logic [MagBits-1:0] m_r [3];
  logic [2*MagBits-1:0] msq_r [3];
  logic [SqBits-1:0] s_r;
  logic signed [DotBits-1:0] dot_r;
  logic [QBits-1:0] q_r [3];
  logic deg_r;
  logic out_v_r;
  logic signed [15:0] onx_r, ony_r, onz_r;
  logic [1:0] ocorn_r;
  logic odeg_r, olast_r;

  logic accept;
  assign accept   = in_valid && in_ready;
  assign in_ready = (st_r == ST_IDLE);

  // shared multiplier: wide operand carries sums, narrow one edges and coords
  logic signed [SumBits-1:0] mul_a;
  logic signed [EdgeBits-1:0] mul_b;
  logic signed [SumBits+EdgeBits-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // cross product edges, per step: (b-a),(c-a) products
  function automatic logic signed [EdgeBits-1:0] dif(coord_t b, coord_t a);
    dif = EdgeBits'(b) - EdgeBits'(a);
  endfunction

  logic [SumBits-1:0] am [3];
  logic [SumBits-1:0] orv;
  logic [5:0] shamt;
  always_comb begin
    for (int i = 0; i < 3; i++) am[i] = n_r[i][SumBits-1] ? SumBits'(-n_r[i]) : n_r[i];
    orv = am[0] | am[1] | am[2];
    shamt = '0;
    for (int b = MagBits; b < SumBits; b++) if (orv[b]) shamt = 6'(b - MagBits + 1);
  end

  // the ratio unit latches the square of the component it starts on
  div_ctl_t dctl;
  logic dstart;
  logic [QBits-1:0] dq;
  qmvn_ratio u_ratio (
    .clk(clk), .rst_n(rst_n), .start(dstart), .msq(msq_r[k_nxt]), .sq(s_r),
    .ctl(dctl), .q(dq)
  );

  // cross product step a: triangle 0,1,2 ; b: 0,2,3. two products per step,
  // the first in half 0, the second in half 1, both on the shared multiplier
  logic tri_b;
  logic [1:0] ca, cb;
  logic half_r, half_nxt;
  logic signed [EdgeBits-1:0] pa, pb;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tri_b = (st_r == ST_X4) || (st_r == ST_X5) || (st_r == ST_X6);
    ca = tri_b ? 2'd2 : 2'd1;
    cb = tri_b ? 2'd3 : 2'd2;
    unique case (st_r)
      ST_X1, ST_X4: begin
        mul_a = SumBits'(dif(vb_r[ca][1], vb_r[0][1]));
        mul_b = dif(vb_r[cb][2], vb_r[0][2]);
      end
      ST_X2, ST_X5: begin
        mul_a = SumBits'(dif(vb_r[ca][2], vb_r[0][2]));
        mul_b = dif(vb_r[cb][0], vb_r[0][0]);
      end
      ST_X3, ST_X6: begin
        mul_a = SumBits'(dif(vb_r[ca][0], vb_r[0][0]));
        mul_b = dif(vb_r[cb][1], vb_r[0][1]);
      end
      ST_SQ: begin
        mul_a = SumBits'(m_r[k_r]);
        mul_b = EdgeBits'(m_r[k_r]);
      end
      ST_NORM: begin
        mul_a = n_r[k_r];
        mul_b = EdgeBits'(vb_r[c_r][k_r]);
      end
      default: ;
    endcase
    // half is only set inside the cross product steps
    if (half_r) begin
      mul_a = SumBits'(pa);
      mul_b = pb;
    end
  end

  always_comb begin
    pa = '0;
    pb = '0;
    unique case (st_r)
      ST_X1, ST_X4: begin
        pa = dif(vb_r[ca][2], vb_r[0][2]);
        pb = dif(vb_r[cb][1], vb_r[0][1]);
      end
      ST_X2, ST_X5: begin
        pa = dif(vb_r[ca][0], vb_r[0][0]);
        pb = dif(vb_r[cb][2], vb_r[0][2]);
      end
      ST_X3, ST_X6: begin
        pa = dif(vb_r[ca][1], vb_r[0][1]);
        pb = dif(vb_r[cb][0], vb_r[0][0]);
      end
      default: ;
    endcase
  end
  logic signed [CrossBits-1:0] p1_r;
  logic signed [CrossBits-1:0] p2;
  assign p2 = CrossBits'(mul_p);

  logic [1:0] xi;
  always_comb begin
    unique case (st_r)
      ST_X1, ST_X4: xi = 2'd0;
      ST_X2, ST_X5: xi = 2'd1;
      default:      xi = 2'd2;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    c_nxt    = c_r;
    half_nxt = half_r;
    dstart   = 1'b0;
    unique case (st_r)
      ST_IDLE: if (accept) begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          st_nxt = ST_X1;
          half_nxt = 1'b0;
        end
      end
      ST_X1, ST_X2, ST_X3, ST_X4, ST_X5: begin
        half_nxt = !half_r;
        if (half_r) st_nxt = state_t'(st_r + 4'd1);
      end
      ST_X6: begin
        half_nxt = !half_r;
        if (half_r) begin
          st_nxt = ST_NSET;
          c_nxt = 2'd0;
        end
      end
      ST_NSET: st_nxt = ST_NORM;
      ST_NORM: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = 2'd0;
          st_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = 2'd0;
          if (deg_r) st_nxt = ST_OUT;
          else begin
            st_nxt = ST_DIV;
            dstart = 1'b1;
          end
        end
      end
      ST_DIV: if (dctl.done) begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = 2'd0;
          st_nxt = ST_OUT;
        end else dstart = 1'b1;
      end
      ST_OUT: if (!out_v_r || out_ready) begin
        c_nxt = c_r + 2'd1;
        st_nxt = (c_r == 2'd3) ? ST_IDLE : ST_NSET;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
      k_r     <= '0;
      c_r     <= '0;
      half_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      k_r    <= k_nxt;
      c_r    <= c_nxt;
      half_r <= half_nxt;
      if (st_r == ST_OUT && (!out_v_r || out_ready)) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  logic signed [15:0] sg [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sg[i] = 16'(q_r[i]);
      if (n_r[i][SumBits-1] ^ dot_r[DotBits-1]) sg[i] = -sg[i];
      if (deg_r) sg[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vb_r[cnt_r][0] <= in_vertex_x;
      vb_r[cnt_r][1] <= in_vertex_y;
      vb_r[cnt_r][2] <= in_vertex_z;
    end
    case (st_r)
      ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6: begin
        if (!half_r) p1_r <= CrossBits'(mul_p);
        else if (tri_b) nb_r[xi] <= p1_r - p2;
        else na_r[xi] <= p1_r - p2;
      end
      ST_NSET: begin
        for (int i = 0; i < 3; i++) begin
          unique case (c_r)
            2'd0, 2'd2: n_r[i] <= SumBits'(na_r[i]) + SumBits'(nb_r[i]);
            2'd1:       n_r[i] <= SumBits'(na_r[i]);
            default:    n_r[i] <= SumBits'(nb_r[i]);
          endcase
        end
        dot_r <= '0;
        s_r   <= '0;
      end
      ST_NORM: begin
        if (k_r == 2'd0) begin
          for (int i = 0; i < 3; i++) m_r[i] <= MagBits'(am[i] >> shamt);
          deg_r <= (orv == '0);
        end
        dot_r <= dot_r + DotBits'(mul_p);
      end
      ST_SQ: begin
        s_r <= s_r + SqBits'(mul_p);
        msq_r[k_r] <= (2*MagBits)'(mul_p);
      end
      ST_DIV: if (dctl.done) q_r[k_r] <= dq;
      ST_OUT: if (!out_v_r || out_ready) begin
        onx_r   <= sg[0];
        ony_r   <= sg[1];
        onz_r   <= sg[2];
        ocorn_r <= c_r;
        odeg_r  <= deg_r;
        olast_r <= (c_r == 2'd3);
      end
      default: ;
    endcase
  end

  assign out_valid        = out_v_r;
  assign out_normal_x     = onx_r;
  assign out_normal_y     = ony_r;
  assign out_normal_z     = onz_r;
  assign out_corner       = ocorn_r;
  assign out_degenerate   = odeg_r;
  assign out_last_of_quad = olast_r;

  a_busy_noready: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.busy |-> !in_ready) else $error("ready while dividing");
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_quad |-> out_corner == 2'd3) else $error("last flag");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == 16'sd0 && out_normal_z == 16'sd0)
    else $error("degenerate nonzero");
endmodule

@@ rtl/core/qmvn_ratio.sv @@
module qmvn_ratio (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [2*qmvn_pkg::MagBits-1:0]   msq,
  input  logic [qmvn_pkg::SqBits-1:0]      sq,
  output qmvn_pkg::div_ctl_t               ctl,
  output logic [qmvn_pkg::QBits-1:0]       q
);
  import qmvn_pkg::*;

  // bit-serial search for the largest r with r*r*s <= x*x*2^30
  // r = floor(2*16384*x/sqrt(s)), then rounded
  // r*r*s and r*s are kept so a trial needs only shifts and adds:
  // (r + 2^b)^2*s = r*r*s + (r*s << (b+1)) + (s << 2b)
  localparam int RBits = QBits + 1;
  localparam int PBits = 2 * RBits + SqBits;

  logic [RBits-1:0]       r_r, r_nxt;
  logic [PBits-1:0]       r2s_r, r2s_nxt;
  logic [PBits-1:0]       rs_r, rs_nxt;
  logic [4:0]             bit_r, bit_nxt;
  logic                   busy_r, busy_nxt, done_r, done_nxt;
  logic [PBits-1:0]       num_r;
  logic [RBits-1:0]       trial;
  logic [PBits-1:0]       sw;
  logic [PBits-1:0]       cand;

  assign trial = r_r | (RBits'(1) << bit_r[3:0]);
  assign sw    = PBits'(sq);
  assign cand  = r2s_r + (rs_r << ({1'b0, bit_r[3:0]} + 5'd1)) + (sw << {bit_r[3:0], 1'b0});

  always_comb begin
    r_nxt    = r_r;
    r2s_nxt  = r2s_r;
    rs_nxt   = rs_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      r_nxt    = '0;
      r2s_nxt  = '0;
      rs_nxt   = '0;
      bit_nxt  = 5'(RBits - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cand <= num_r) begin
        r_nxt   = trial;
        r2s_nxt = cand;
        rs_nxt  = rs_r + (sw << bit_r[3:0]);
      end
      if (bit_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    r_r   <= r_nxt;
    r2s_r <= r2s_nxt;
    rs_r  <= rs_nxt;
    bit_r <= bit_nxt;
    if (start) num_r <= PBits'(msq) << 30;
  end

  // r = floor(2*16384*x/sqrt(s)), capped; rounded result = ceil-half of r/2
  logic [RBits-1:0] rc;
  assign rc = (r_r > RBits'(32768)) ? RBits'(32768) : r_r;
  assign q  = QBits'((rc + RBits'(1)) >> 1);
  assign ctl = '{start: start, busy: busy_r, done: done_r};
endmodule

@@ verif/quad_mesh_vertex_normals_checker.sv @@
`timescale 1ns / 1ps

module quad_mesh_vertex_normals_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic signed [15:0] in_vertex_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic [1:0]         out_corner,
  input  logic               out_degenerate,
  input  logic               out_last_of_quad,
  output int                 fail_count,
  output int                 pending_normals
);

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         corner;
    logic               degenerate;
    logic               last;
  } vnormal_t;

  vnormal_t normal_q[$];
  longint   held_verts[3][3];
  int       corners_seen;

  // nearest integer to 16384 * x / sqrt(s), ties away from zero
  function automatic longint unit_ratio(longint x, longint s);
    longint num, lo, hi, mid;
    num = (x * x) <<< 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) >>> 1;
      if (mid * mid * s <= num) lo = mid;
      else hi = mid - 1;
    end
    if (lo < 16384 && (2 * lo + 1) * (2 * lo + 1) * s <= (num <<< 2)) lo++;
    return lo;
  endfunction

  function automatic vnormal_t corner_normal(longint n[3], longint v[3], int k);
    vnormal_t r;
    longint mag[3];
    longint s, dot, q;
    int sh;
    r.corner = k[1:0];
    r.last = (k == 3);
    for (int i = 0; i < 3; i++) mag[i] = (n[i] < 0) ? -n[i] : n[i];
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      r.nx = 0; r.ny = 0; r.nz = 0; r.degenerate = 1'b1;
      return r;
    end
    sh = 0;
    while ((mag[0] >>> sh) >= 65536 || (mag[1] >>> sh) >= 65536 || (mag[2] >>> sh) >= 65536)
      sh++;
    for (int i = 0; i < 3; i++) mag[i] = mag[i] >>> sh;
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    dot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
    r.degenerate = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = unit_ratio(mag[i], s);
      if (n[i] < 0) q = -q;
      if (dot < 0) q = -q;
      if (i == 0) r.nx = q[15:0];
      else if (i == 1) r.ny = q[15:0];
      else r.nz = q[15:0];
    end
    return r;
  endfunction

  function automatic void tri_cross(longint a[3], longint b[3], longint c[3],
                                    output longint n[3]);
    longint e1[3], e2[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
  endfunction

  task automatic take_vertex(longint px, longint py, longint pz);
    longint vq[4][3];
    longint na[3], nb[3], n[3];
    if (corners_seen < 3) begin
      held_verts[corners_seen][0] = px;
      held_verts[corners_seen][1] = py;
      held_verts[corners_seen][2] = pz;
      corners_seen++;
      return;
    end
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) vq[k][i] = held_verts[k][i];
    vq[3][0] = px; vq[3][1] = py; vq[3][2] = pz;
    corners_seen = 0;
    tri_cross(vq[0], vq[1], vq[2], na);
    tri_cross(vq[0], vq[2], vq[3], nb);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++)
        n[i] = (k == 1) ? na[i] : (k == 3) ? nb[i] : na[i] + nb[i];
      normal_q.push_back(corner_normal(n, vq[k], k));
    end
  endtask

  initial fail_count = 0;
  initial corners_seen = 0;
  initial pending_normals = 0;

  always @(posedge clk) begin
    vnormal_t e;
    if (rst_n) begin
      if (in_valid && in_ready)
        take_vertex(longint'(in_vertex_x), longint'(in_vertex_y), longint'(in_vertex_z));
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          $error("unexpected normal beat");
          fail_count++;
        end else begin
          e = normal_q.pop_front();
          if (out_normal_x !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, out_normal_x); fail_count++;
          end
          if (out_normal_y !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, out_normal_y); fail_count++;
          end
          if (out_normal_z !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, out_normal_z); fail_count++;
          end
          if (out_corner !== e.corner) begin
            $error("corner exp %0d got %0d", e.corner, out_corner); fail_count++;
          end
          if (out_degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, out_degenerate);
            fail_count++;
          end
          if (out_last_of_quad !== e.last) begin
            $error("last_of_quad exp %0d got %0d", e.last, out_last_of_quad);
            fail_count++;
          end
        end
      end
    end
    pending_normals = normal_q.size();
  end

endmodule

@@ verif/quad_mesh_vertex_normals_tb.sv @@
`timescale 1ns / 1ps

module quad_mesh_vertex_normals_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_vertex_x;
  logic signed [15:0] in_vertex_y;
  logic signed [15:0] in_vertex_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_normal_x;
  logic signed [15:0] out_normal_y;
  logic signed [15:0] out_normal_z;
  logic [1:0]         out_corner;
  logic               out_degenerate;
  logic               out_last_of_quad;
  int                 fail_count;
  int                 pending_normals;
  bit                 rx_hold_req;   // sender asks receiver for a long hold-off

  quad_mesh_vertex_normals DUT (.*);

  quad_mesh_vertex_normals_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit: ~80 quads, random stalls per beat and one long hold-off all
  // finish well under it
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // one vertex beat; optional idle gap first, then hold valid until accepted
  // valid stays high after the beat, the caller drops it when it pauses
  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_vertex_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_quad(logic [15:0] q[12], bit gaps);
    for (int k = 0; k < 4; k++) send_vertex(q[3*k], q[3*k+1], q[3*k+2], gaps);
  endtask

  // random coordinate: mostly full range, sometimes small or an extreme
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return 16'(int'($urandom_range(0, 64)) - 32);
      1:       return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall per beat, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (1500) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    logic [15:0] q[12];
    int wait_cnt;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_vertex_x = '0;
    in_vertex_y = '0;
    in_vertex_z = '0;
    rx_hold_req = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: unit square at the origin, degenerate quad (all same), extremes
    q = '{16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000,
          16'h1000, 16'h1000, 16'h0000, 16'h0000, 16'h1000, 16'h0000};
    send_quad(q, 0);
    q = '{16'h0123, 16'h0456, 16'h0789, 16'h0123, 16'h0456, 16'h0789,
          16'h0123, 16'h0456, 16'h0789, 16'h0123, 16'h0456, 16'h0789};
    send_quad(q, 0);
    q = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
          16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
    send_quad(q, 0);
    // collinear first triangle: corner 1 degenerate, others not
    q = '{16'h1000, 16'h1000, 16'h1000, 16'h2000, 16'h2000, 16'h2000,
          16'h3000, 16'h3000, 16'h3000, 16'hf000, 16'h4000, 16'h0800};
    send_quad(q, 0);
    // facing away from the position: negation path
    q = '{16'h0000, 16'h0000, 16'h2000, 16'h0000, 16'h1000, 16'h2000,
          16'h1000, 16'h1000, 16'h2000, 16'h1000, 16'h0000, 16'h2000};
    send_quad(q, 1);
    q = '{16'hffff, 16'h0001, 16'h7fff, 16'h8000, 16'hffff, 16'h0000,
          16'h0001, 16'h8000, 16'hfffe, 16'h7ffe, 16'h5555, 16'haaaa};
    send_quad(q, 1);

    // pressure: long receiver hold while the sender keeps offering
    rx_hold_req = 1'b1;
    for (int k = 0; k < 3; k++) begin
      foreach (q[i]) q[i] = rand_coord();
      send_quad(q, 0);
    end
    // sender pauses until every expected normal is back
    in_valid <= 1'b0;
    while (pending_normals != 0) @(negedge clk);

    // random part, ~280 vertices
    for (int n = 0; n < 70; n++) begin
      foreach (q[i]) q[i] = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 3; i < 12; i++) q[i] = q[i % 3];  // whole quad degenerate
      end
      send_quad(q, $urandom_range(0, 4) != 0);
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_normals != 0 && wait_cnt < 200000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_normals == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/qmvn_pkg.sv
rtl/core/qmvn_ratio.sv
rtl/core/quad_mesh_vertex_normals.sv
verif/quad_mesh_vertex_normals_checker.sv
verif/quad_mesh_vertex_normals_tb.sv
